// ===== sv/assert_macros.svh =====
// Assertion macros shared by the pixel converter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define RCV_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define RCV_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// ===== sv/rcv_pkg.sv =====
// Package for the RGB to YCbCr / HSV pixel converter: constants, types, weight helper.
// No dependencies.
`timescale 1ns / 1ps

package rcv_pkg;

    localparam int unsigned COEF_FRAC_BITS_DEF = 16;

    // color_mode codes
    localparam logic [1:0] MODE_RGB   = 2'd0;
    localparam logic [1:0] MODE_YCBCR = 2'd1;
    localparam logic [1:0] MODE_HSV   = 2'd2;

    // divider geometry: numerator < 2^20, denominator < 2^12, quotient < 2^9
    localparam int unsigned DIV_NUM_W = 20;
    localparam int unsigned DIV_DEN_W = 12;
    localparam int unsigned DIV_Q_W   = 9;

    // per-pixel data that rides beside the divider stages
    typedef struct packed {
        logic       hsv;
        logic       zero;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } side_t;

    // weight in parts per ten thousand, rounded to frac fraction bits
    function automatic longint unsigned rcv_coef(longint unsigned w10k, int unsigned frac);
        return ((w10k << frac) + 64'd5000) / 64'd10000;
    endfunction

endpackage

// ===== sv/rcv_div_stage.sv =====
// One registered bit step of a restoring divider.
// Depends on rcv_pkg for default widths.
`timescale 1ns / 1ps

module rcv_div_stage #(
    parameter int unsigned NUM_W = rcv_pkg::DIV_NUM_W,
    parameter int unsigned DEN_W = rcv_pkg::DIV_DEN_W,
    parameter int unsigned Q_W   = rcv_pkg::DIV_Q_W,
    parameter int unsigned SHIFT = 0
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] rem_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [Q_W-1:0]   q_in,
    output logic [NUM_W-1:0] rem_out,
    output logic [DEN_W-1:0] den_out,
    output logic [Q_W-1:0]   q_out
);
    import rcv_pkg::*;

    localparam int unsigned CMP_W = NUM_W + DEN_W + Q_W;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic             ge;
    logic [NUM_W-1:0] rem_next;
    logic [Q_W-1:0]   q_next;
    logic [NUM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;

    always_comb
    begin
        rem_ext  = CMP_W'(rem_in);
        den_sh   = CMP_W'(den_in) << SHIFT;
        ge       = (rem_ext >= den_sh);
        rem_next = ge ? NUM_W'(rem_ext - den_sh) : rem_in;
        q_next   = q_in | (Q_W'(ge) << SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

// ===== sv/rgb_to_ycbcr_hsv_pixel_converter_unit.sv =====
// Pipeline: 13 register stages, the first loaded at the input transfer; one pixel per
//   cycle sustained while the output is not stalled.
// Stages: input capture, weight products / max-min, sums and divider operands,
//   nine restoring-divider bit stages, output select register.
// A stalled output freezes the whole pipe; in_ready = !out_valid || out_ready.
// Reset (rst_n, async, low) clears all valid bits and color_mode (passthrough).
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_to_ycbcr_hsv_pixel_converter_unit #(
    parameter int unsigned COEF_FRAC_BITS = rcv_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] chan0_out,
    output logic [7:0] chan1_out,
    output logic [7:0] chan2_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);
    import rcv_pkg::*;

    localparam int unsigned F     = COEF_FRAC_BITS;
    localparam int unsigned PW    = F + 8;          // weight x sample
    localparam int unsigned ACC_W = F + 12;         // signed sum with offset
    localparam int unsigned NSTG  = 13;
    localparam int unsigned DIV0  = 3;              // valid index of first divider stage

    localparam logic [F-1:0] C_YR  = F'(rcv_coef(2990, F));
    localparam logic [F-1:0] C_YG  = F'(rcv_coef(5870, F));
    localparam logic [F-1:0] C_YB  = F'(rcv_coef(1140, F));
    localparam logic [F-1:0] C_BR  = F'(rcv_coef(1687, F));
    localparam logic [F-1:0] C_BG  = F'(rcv_coef(3313, F));
    localparam logic [F-1:0] C_HALF = F'(rcv_coef(5000, F));
    localparam logic [F-1:0] C_RG  = F'(rcv_coef(4187, F));
    localparam logic [F-1:0] C_RB  = F'(rcv_coef(813, F));

    // ---------------- control ----------------
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [1:0]      color_mode_reg;

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[NSTG-1];

    always_comb
    begin
        vld_next = {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            color_mode_reg <= MODE_RGB;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (cfg_valid)
                color_mode_reg <= cfg_data;
        end
    end

    // ---------------- stage A: capture ----------------
    logic [7:0] r_a_reg, g_a_reg, b_a_reg;
    logic [1:0] mode_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_a_reg    <= red_in;
            g_a_reg    <= green_in;
            b_a_reg    <= blue_in;
            mode_a_reg <= color_mode_reg;
        end
    end

    // ---------------- stage B: products, max/min, hue numerator ----------------
    logic [7:0]        mx_b_next, mn_b_next, d_b_next;
    logic signed [12:0] n_raw;
    logic [10:0]       n_b_next;
    logic [PW-1:0]     p_b_reg [9];
    logic [7:0]        r_b_reg, g_b_reg, b_b_reg, mx_b_reg, d_b_reg;
    logic [10:0]       n_b_reg;
    logic [1:0]        mode_b_reg;

    always_comb
    begin
        mx_b_next = r_a_reg;
        if (g_a_reg > mx_b_next) mx_b_next = g_a_reg;
        if (b_a_reg > mx_b_next) mx_b_next = b_a_reg;
        mn_b_next = r_a_reg;
        if (g_a_reg < mn_b_next) mn_b_next = g_a_reg;
        if (b_a_reg < mn_b_next) mn_b_next = b_a_reg;
        d_b_next = mx_b_next - mn_b_next;
        // sector rule, red first, then green, then blue
        if (r_a_reg == mx_b_next)
            n_raw = $signed({5'b0, g_a_reg}) - $signed({5'b0, b_a_reg});
        else if (g_a_reg == mx_b_next)
            n_raw = $signed({4'b0, d_b_next, 1'b0}) + $signed({5'b0, b_a_reg})
                  - $signed({5'b0, r_a_reg});
        else
            n_raw = $signed({3'b0, d_b_next, 2'b0}) + $signed({5'b0, r_a_reg})
                  - $signed({5'b0, g_a_reg});
        if (n_raw < 0)
            n_raw = n_raw + $signed(13'(d_b_next) * 13'd6);
        n_b_next = n_raw[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_b_reg[0] <= PW'(C_YR)   * PW'(r_a_reg);
            p_b_reg[1] <= PW'(C_YG)   * PW'(g_a_reg);
            p_b_reg[2] <= PW'(C_YB)   * PW'(b_a_reg);
            p_b_reg[3] <= PW'(C_BR)   * PW'(r_a_reg);
            p_b_reg[4] <= PW'(C_BG)   * PW'(g_a_reg);
            p_b_reg[5] <= PW'(C_HALF) * PW'(b_a_reg);
            p_b_reg[6] <= PW'(C_HALF) * PW'(r_a_reg);
            p_b_reg[7] <= PW'(C_RG)   * PW'(g_a_reg);
            p_b_reg[8] <= PW'(C_RB)   * PW'(b_a_reg);
            r_b_reg    <= r_a_reg;
            g_b_reg    <= g_a_reg;
            b_b_reg    <= b_a_reg;
            mx_b_reg   <= mx_b_next;
            d_b_reg    <= d_b_next;
            n_b_reg    <= n_b_next;
            mode_b_reg <= mode_a_reg;
        end
    end

    // ---------------- stage C: sums, rounding, divider operands ----------------
    function automatic logic [7:0] round_clamp(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        t = acc + (ACC_W'(1) << (F - 1));
        if (t[ACC_W-1])
            return 8'd0;
        else if (|t[ACC_W-2:F+8])
            return 8'd255;
        else
            return t[F+7:F];
    endfunction

    logic signed [ACC_W-1:0] sp [9];
    logic signed [ACC_W-1:0] off;
    logic [7:0]              y_c, cb_c, cr_c;
    side_t                   side_c_next;
    side_t                   side_c_reg;
    logic [DIV_NUM_W-1:0]    hnum_c_reg, snum_c_reg;
    logic [DIV_DEN_W-1:0]    hden_c_reg, sden_c_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            sp[k] = $signed(ACC_W'(p_b_reg[k]));
        off  = $signed(ACC_W'(128) << F);
        y_c  = round_clamp(sp[0] + sp[1] + sp[2]);
        cb_c = round_clamp(off - sp[3] - sp[4] + sp[5]);
        cr_c = round_clamp(off + sp[6] - sp[7] - sp[8]);

        side_c_next.hsv  = (mode_b_reg == MODE_HSV);
        side_c_next.zero = (d_b_reg == 8'd0);
        side_c_next.c0   = r_b_reg;
        side_c_next.c1   = g_b_reg;
        side_c_next.c2   = b_b_reg;
        case (mode_b_reg)
            MODE_YCBCR:
            begin
                side_c_next.c0 = y_c;
                side_c_next.c1 = cb_c;
                side_c_next.c2 = cr_c;
            end
            MODE_HSV:
            begin
                side_c_next.c2 = mx_b_reg;
            end
            default:
            begin
                side_c_next.c0 = r_b_reg;   // passthrough, also the unused code
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_c_reg <= side_c_next;
            hnum_c_reg <= DIV_NUM_W'(n_b_reg) * DIV_NUM_W'(510)
                        + DIV_NUM_W'(d_b_reg) * DIV_NUM_W'(6);
            hden_c_reg <= DIV_DEN_W'(d_b_reg) * DIV_DEN_W'(12);
            snum_c_reg <= DIV_NUM_W'(d_b_reg) * DIV_NUM_W'(510) + DIV_NUM_W'(mx_b_reg);
            sden_c_reg <= DIV_DEN_W'(mx_b_reg) << 1;
        end
    end

    // ---------------- divider stages: one quotient bit each ----------------
    logic [DIV_NUM_W-1:0] h_rem [DIV_Q_W+1];
    logic [DIV_DEN_W-1:0] h_den [DIV_Q_W+1];
    logic [DIV_Q_W-1:0]   h_q   [DIV_Q_W+1];
    logic [DIV_NUM_W-1:0] s_rem [DIV_Q_W+1];
    logic [DIV_DEN_W-1:0] s_den [DIV_Q_W+1];
    logic [DIV_Q_W-1:0]   s_q   [DIV_Q_W+1];
    side_t                side_d_reg [DIV_Q_W+1];

    assign h_rem[0]      = hnum_c_reg;
    assign h_den[0]      = hden_c_reg;
    assign h_q[0]        = '0;
    assign s_rem[0]      = snum_c_reg;
    assign s_den[0]      = sden_c_reg;
    assign s_q[0]        = '0;
    assign side_d_reg[0] = side_c_reg;

    for (genvar k = 0; k < DIV_Q_W; k++)
    begin : g_div
        rcv_div_stage #(
            .NUM_W (DIV_NUM_W),
            .DEN_W (DIV_DEN_W),
            .Q_W   (DIV_Q_W),
            .SHIFT (DIV_Q_W - 1 - k)
        ) u_hue (
            .clk     (clk),
            .en      (en),
            .rem_in  (h_rem[k]),
            .den_in  (h_den[k]),
            .q_in    (h_q[k]),
            .rem_out (h_rem[k+1]),
            .den_out (h_den[k+1]),
            .q_out   (h_q[k+1])
        );

        rcv_div_stage #(
            .NUM_W (DIV_NUM_W),
            .DEN_W (DIV_DEN_W),
            .Q_W   (DIV_Q_W),
            .SHIFT (DIV_Q_W - 1 - k)
        ) u_sat (
            .clk     (clk),
            .en      (en),
            .rem_in  (s_rem[k]),
            .den_in  (s_den[k]),
            .q_in    (s_q[k]),
            .rem_out (s_rem[k+1]),
            .den_out (s_den[k+1]),
            .q_out   (s_q[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
                side_d_reg[k+1] <= side_d_reg[k];
        end
    end

    // ---------------- output stage ----------------
    side_t                side_o;
    logic [DIV_Q_W-1:0]   hq_o, sq_o;
    logic [7:0]           chan0_next, chan1_next;
    logic [7:0]           chan0_reg, chan1_reg, chan2_reg;

    always_comb
    begin
        side_o     = side_d_reg[DIV_Q_W];
        hq_o       = h_q[DIV_Q_W];
        sq_o       = s_q[DIV_Q_W];
        chan0_next = side_o.c0;
        chan1_next = side_o.c1;
        if (side_o.hsv)
        begin
            if (side_o.zero)
            begin
                // grey or black pixel: hue and saturation are zero
                chan0_next = 8'd0;
                chan1_next = 8'd0;
            end
            else
            begin
                chan0_next = hq_o[DIV_Q_W-1] ? 8'd255 : hq_o[7:0];
                chan1_next = sq_o[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chan0_reg <= chan0_next;
            chan1_reg <= chan1_next;
            chan2_reg <= side_o.c2;
        end
    end

    assign chan0_out = chan0_reg;
    assign chan1_out = chan1_reg;
    assign chan2_out = chan2_reg;

    // ---------------- checks ----------------
    // live HSV quotient at the divider output
    logic hsv_chk;
    assign hsv_chk = vld_reg[DIV0+DIV_Q_W-1] && side_o.hsv && !side_o.zero;

    `RCV_ASSERT(a_stall_freezes_valids, clk, rst_n, !en |=> $stable(vld_reg), "valids moved")
    `RCV_ASSERT(a_sat_fits_byte, clk, rst_n, hsv_chk |-> !sq_o[DIV_Q_W-1], "sat overflow")
    `RCV_ASSERT(a_hue_bound, clk, rst_n, hsv_chk |-> (hq_o <= DIV_Q_W'(257)), "hue overflow")

endmodule

// ===== tb/sv/rgb_to_ycbcr_hsv_pixel_converter_unit_tb.sv =====
// Testbench for the RGB to YCbCr / HSV pixel converter: self-checking, queue-driven.
// Depends on rcv_pkg (mode codes) and the converter top level.
`timescale 1ns / 1ps

module rgb_to_ycbcr_hsv_pixel_converter_unit_tb;
    import rcv_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = '0;

    // Items waiting to be driven, and results still owed by the block.
    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    logic [1:0] mode_shadow = MODE_RGB;
    int errors = 0;
    int stall_cycles = 0;
    bit idle_enable = 1'b1;
    bit hold_sender = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    rgb_to_ycbcr_hsv_pixel_converter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .chan0_out (chan0_out),
        .chan1_out (chan1_out),
        .chan2_out (chan2_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Q16 weight from parts per ten thousand, rounded to nearest.
    function automatic longint weight(longint w10k);
        return ((w10k << FRAC) + 5000) / 10000;
    endfunction

    function automatic logic [7:0] round_clamp(longint acc);
        longint v;
        acc = acc + (longint'(1) << (FRAC - 1));
        if (acc < 0)
            return 8'd0;
        v = acc >>> FRAC;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Converted pixel for the given mode.
    function automatic pixel_t convert_pixel(pixel_t p, logic [1:0] mode);
        longint r, g, b, mx, mn, d, n, off, h, s;
        pixel_t q;
        r = p.r;
        g = p.g;
        b = p.b;
        q = p;
        if (mode == MODE_YCBCR) begin
            off = longint'(128) << FRAC;
            q.r = round_clamp(weight(2990) * r + weight(5870) * g + weight(1140) * b);
            q.g = round_clamp(-weight(1687) * r - weight(3313) * g + weight(5000) * b + off);
            q.b = round_clamp(weight(5000) * r - weight(4187) * g - weight(813) * b + off);
        end
        else if (mode == MODE_HSV) begin
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            q.r = 8'd0;
            q.g = 8'd0;
            q.b = mx[7:0];
            if (mx > 0 && d > 0) begin
                s = (510 * d + mx) / (2 * mx);
                q.g = s[7:0];
                if (r == mx)
                    n = g - b;
                else if (g == mx)
                    n = 2 * d + (b - r);
                else
                    n = 4 * d + (r - g);
                if (n < 0)
                    n = n + 6 * d;
                h = (510 * n + 6 * d) / (12 * d);
                q.r = (h > 255) ? 8'd255 : h[7:0];
            end
        end
        return q;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int kind;
        kind = $urandom_range(0, 9);
        p = pixel_t'(24'($urandom));
        if (kind == 0) begin
            p.g = p.r;                      // grey
            p.b = p.r;
        end
        else if (kind == 1) begin
            p.r = 8'($urandom_range(0, 3)); // near black
            p.g = 8'($urandom_range(0, 3));
            p.b = 8'($urandom_range(0, 3));
        end
        else if (kind == 2) begin
            p.r = p.g;                      // red and green tied
        end
        return p;
    endfunction

    // Driver: pops pending items, holds valid until the transfer.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready)
                expected_pixels.push_back(convert_pixel({red_in, green_in, blue_in},
                                                        mode_shadow));
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!hold_sender && pending_pixels.size() > 0) begin
                    pixel_t p;
                    p = pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    red_in <= p.r;
                    green_in <= p.g;
                    blue_in <= p.b;
                    if (idle_enable && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer and paces out_ready.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("output transfer with nothing expected");
                    errors++;
                end
                else begin
                    pixel_t e;
                    e = expected_pixels.pop_front();
                    if (chan0_out !== e.r) begin
                        $error("chan0_out expected %0d got %0d", e.r, chan0_out);
                        errors++;
                    end
                    if (chan1_out !== e.g) begin
                        $error("chan1_out expected %0d got %0d", e.g, chan1_out);
                        errors++;
                    end
                    if (chan2_out !== e.b) begin
                        $error("chan2_out expected %0d got %0d", e.b, chan2_out);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 6);
            end
        end
    end

    // Watchdog: cycles with no transfer on any channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_to_ycbcr_hsv_pixel_converter_unit_tb failed");
            $finish;
        end
    end

    // Mode change while idle; sampled mid-cycle so the driver's updates have settled.
    task automatic set_mode(logic [1:0] mode);
        @(negedge clk);
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_shadow = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_directed();
        pixel_t edge_pixels[10];
        edge_pixels = '{{8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255},
                        {8'd255, 8'd0, 8'd0}, {8'd0, 8'd255, 8'd0},
                        {8'd0, 8'd0, 8'd255}, {8'd255, 8'd0, 8'd1},
                        {8'd128, 8'd128, 8'd128}, {8'd0, 8'd255, 8'd255},
                        {8'd255, 8'd255, 8'd0}, {8'd1, 8'd0, 8'd0}};
        foreach (edge_pixels[i])
            pending_pixels.push_back(edge_pixels[i]);
    endtask

    initial begin
        logic [1:0] mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, primaries, grey and black in every mode, reset mode first.
        queue_directed();
        set_mode(MODE_YCBCR);
        queue_directed();
        set_mode(MODE_HSV);
        queue_directed();
        set_mode(2'd3);                     // unused code behaves as passthrough
        queue_directed();

        // Random phases across all modes.
        for (int phase = 0; phase < 12; phase++) begin
            mode = 2'($urandom_range(0, 3));
            if (phase == 11)
                idle_enable = 1'b0;         // last stretch runs without idling
            set_mode(phase < 4 ? 2'(phase) : mode);
            for (int i = 0; i < 92; i++)
                pending_pixels.push_back(random_pixel());
            if (phase == 5) begin
                // sender holds off until every result is back
                while (pending_pixels.size() > 46)
                    @(posedge clk);
                hold_sender = 1'b1;
                @(negedge clk);
                while (in_valid || expected_pixels.size() > 0)
                    @(negedge clk);
                hold_sender = 1'b0;
            end
        end

        @(negedge clk);
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("rgb_to_ycbcr_hsv_pixel_converter_unit_tb passed");
        else
            $display("rgb_to_ycbcr_hsv_pixel_converter_unit_tb failed");
        $finish;
    end

endmodule
